>>> rtl/core/quadrature_position_speed_tracker_defines.svh
// ----------------------------------------------------------------------------
// Quadrature position and speed tracker: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_POSITION_SPEED_TRACKER_DEFINES_SVH
`define QUADRATURE_POSITION_SPEED_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define QPST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define QPST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/qpst_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature position and speed tracker: shared package
// Operation and register codes, arithmetic constants, controller interface.
// ----------------------------------------------------------------------------
package qpst_pkg;

    // Operation carried in the input tuser
    typedef enum logic [1:0] {
        OP_POS  = 2'd0,
        OP_VEL  = 2'd1,
        OP_ZERO = 2'd2
    } t_op;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_POS_MAX    = 2'd0,
        CFG_POLE_PAIRS = 2'd1,
        CFG_CAL_ANGLE  = 2'd2,
        CFG_SINE_MODE  = 2'd3
    } t_cfg_idx;

    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int POLE_W       = 7;

    localparam int WORD_W       = 32;
    localparam int TURNS_W      = 16;
    localparam int CAP_W        = 16;

    // Speed scaling
    localparam logic [8:0]  COARSE_GAIN = 9'd273;
    localparam logic [15:0] FINE_COEF   = 16'd61404;
    localparam int Q_FRAC       = 24;
    localparam int MECH_SHIFT   = 3;

    // Restoring divider: (timer << Q_FRAC) / period, one quotient bit a cycle
    localparam int DIVIDEND_W   = CAP_W + Q_FRAC;
    localparam int DIV_STEPS    = DIVIDEND_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int Q_W          = 31;
    localparam int PROD_W       = Q_W + 16;
    localparam int FINE_W       = PROD_W - Q_FRAC;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic front;
        logic div_step;
        logic mul;
        logic commit;
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic div_done;
    } t_ctl_sts;

endpackage

>>> rtl/core/qpst_ctrl.sv
// ----------------------------------------------------------------------------
// Quadrature position and speed tracker: controller
// Sequences one word through front, divide, multiply and commit steps (divide and
// multiply for velocity words only) and owns the input ready and output valid flags.
// ----------------------------------------------------------------------------
module qpst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    input  qpst_pkg::t_ctl_sts i_sts,
    output qpst_pkg::t_ctl_cmd o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid
);
    import qpst_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FRONT  = 5'b00010,
        S_DIV    = 5'b00100,
        S_MUL    = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FRONT;
                end
            end
            S_FRONT: begin
                o_cmd.front = 1'b1;
                n_state     = (i_sts.op == OP_VEL) ? S_DIV : S_COMMIT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the output register is free
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output word flag: set on commit, drop when taken
    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/qpst_datapath.sv
// ----------------------------------------------------------------------------
// Quadrature position and speed tracker: datapath
// Configuration registers, tracking state, count unwrap, angle products,
// restoring divider for the fine speed term and the output register.
// ----------------------------------------------------------------------------
module qpst_datapath #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  qpst_pkg::t_ctl_cmd                   i_cmd,
    output qpst_pkg::t_ctl_sts                   o_sts,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [qpst_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [qpst_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input word fields
    input  logic [1:0]                           i_operation,
    input  logic [qpst_pkg::WORD_W-1:0]          i_count,
    input  logic [qpst_pkg::WORD_W-1:0]          i_index_count,
    input  logic                                 i_dir_forward,
    input  logic                                 i_index_event,
    input  logic [qpst_pkg::CAP_W-1:0]           i_cap_timer,
    input  logic [qpst_pkg::CAP_W-1:0]           i_cap_period,
    input  logic                                 i_cap_overflow,
    input  logic                                 i_dir_changed,
    // output word fields
    output logic signed [qpst_pkg::WORD_W-1:0]   o_position,
    output logic signed [qpst_pkg::WORD_W-1:0]   o_step,
    output logic signed [qpst_pkg::TURNS_W-1:0]  o_turns,
    output logic [qpst_pkg::WORD_W-1:0]          o_raw_angle,
    output logic [qpst_pkg::WORD_W-1:0]          o_mech_angle,
    output logic [qpst_pkg::WORD_W-1:0]          o_elec_angle,
    output logic                                 o_use_hall,
    output logic signed [qpst_pkg::WORD_W-1:0]   o_speed
);
    import qpst_pkg::*;

    localparam int CW = COUNT_WIDTH;

    // Configuration
    logic [CW-1:0]         r_pos_max;
    logic [POLE_W-1:0]     r_pole_pairs;
    logic [WORD_W-1:0]     r_cal_angle;
    logic                  r_sine_mode;

    // Tracking state
    logic [CW-1:0]         r_last_count, n_last_count;
    logic [WORD_W-1:0]     r_accum, n_accum;
    logic [TURNS_W-1:0]    r_revs, n_revs;
    logic                  r_index_seen, n_index_seen;
    logic [WORD_W-1:0]     r_speed_ref, n_speed_ref;
    logic [WORD_W-1:0]     r_last_step, n_last_step;

    // Latched input word
    t_op                   r_op;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_icnt;
    logic                  r_fwd;
    logic                  r_idx;
    logic [CAP_W-1:0]      r_period;
    logic                  r_ovf;
    logic                  r_dchg;

    // Intermediate results
    logic [WORD_W-1:0]     r_raw, r_mech, r_elec_prod, r_step_new, r_coarse;
    logic [FINE_W-1:0]     r_fine;
    logic [CAP_W-1:0]      r_div_rem;
    logic [DIVIDEND_W-1:0] r_div_quo;
    logic [DIV_CNT_W-1:0]  r_div_cnt;

    logic [WORD_W-1:0]     w_raw, w_mech, w_elec_prod, w_step, w_coarse;
    logic [WORD_W-1:0]     w_old, w_cur, w_pmax, w_mid;
    logic [CAP_W:0]        w_rem_sh;
    logic                  w_ge;
    logic [Q_W-1:0]        w_q_sat;
    logic [PROD_W-1:0]     w_fine_prod;
    logic [WORD_W-1:0]     w_fine_sel, w_speed;
    logic [WORD_W-1:0]     w_out_raw, w_out_mech, w_out_elec, w_out_speed;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_max    <= '1;
            r_pole_pairs <= POLE_W'(1);
            r_cal_angle  <= '0;
            r_sine_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_POS_MAX:    r_pos_max    <= i_cfg_data[CW-1:0];
                CFG_POLE_PAIRS: r_pole_pairs <= i_cfg_data[POLE_W-1:0];
                CFG_CAL_ANGLE:  r_cal_angle  <= i_cfg_data;
                CFG_SINE_MODE:  r_sine_mode  <= i_cfg_data[0];
                default:        r_sine_mode  <= r_sine_mode;
            endcase
        end
    end

    // Angles from the latched counts
    assign w_raw       = WORD_W'(r_cnt) - WORD_W'(r_icnt);
    assign w_mech      = w_raw << MECH_SHIFT;
    assign w_elec_prod = w_mech * WORD_W'(r_pole_pairs);

    // Unwrap the count change around half of the wrap value
    assign w_old  = WORD_W'(r_last_count);
    assign w_cur  = WORD_W'(r_cnt);
    assign w_pmax = WORD_W'(r_pos_max);
    assign w_mid  = w_pmax >> 1;

    always_comb begin
        if ((w_old > w_cur) && (w_old > w_mid) && (w_cur < w_mid)) begin
            // forward wrap through zero
            w_step = w_pmax - w_old + w_cur + WORD_W'(1);
        end else if (w_old > w_cur) begin
            w_step = w_cur - w_old;
        end else if ((w_cur > w_mid) && (w_old < w_mid)) begin
            // backward wrap through zero
            w_step = WORD_W'(0) - (w_pmax - w_cur + w_old + WORD_W'(1));
        end else begin
            w_step = w_cur - w_old;
        end
    end

    // Coarse speed from the position change since the last velocity word
    assign w_coarse = (r_accum - r_speed_ref) * WORD_W'(COARSE_GAIN);

    // One restoring divide step
    assign w_rem_sh = {r_div_rem, r_div_quo[DIVIDEND_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_period});

    // Saturate the quotient and scale
    assign w_q_sat     = (|r_div_quo[DIVIDEND_W-1:Q_W]) ? '1 : r_div_quo[Q_W-1:0];
    assign w_fine_prod = PROD_W'(w_q_sat) * PROD_W'(FINE_COEF);

    // Latch the input word, run front, divide and multiply steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= t_op'(i_operation);
            r_cnt     <= i_count[CW-1:0];
            r_icnt    <= i_index_count[CW-1:0];
            r_fwd     <= i_dir_forward;
            r_idx     <= i_index_event;
            r_period  <= i_cap_period;
            r_ovf     <= i_cap_overflow;
            r_dchg    <= i_dir_changed;
            r_div_rem <= '0;
            r_div_quo <= {i_cap_timer, Q_FRAC'(0)};
        end else if (i_cmd.div_step) begin
            r_div_rem <= w_ge ? CAP_W'(w_rem_sh - {1'b0, r_period}) : w_rem_sh[CAP_W-1:0];
            r_div_quo <= {r_div_quo[DIVIDEND_W-2:0], w_ge};
        end
        if (i_cmd.front) begin
            r_raw       <= w_raw;
            r_mech      <= w_mech;
            r_elec_prod <= w_elec_prod;
            r_step_new  <= w_step;
            r_coarse    <= w_coarse;
        end
        if (i_cmd.mul) begin
            r_fine <= w_fine_prod[PROD_W-1:Q_FRAC];
        end
    end

    // Divide step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.load) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.div_done = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    // Fine term select: direction change wins over overflow
    always_comb begin
        if (r_dchg) begin
            w_fine_sel = '0;
        end else if (r_ovf) begin
            w_fine_sel = WORD_W'(COARSE_GAIN);
        end else begin
            w_fine_sel = WORD_W'(r_fine);
        end
    end
    assign w_speed = r_coarse + w_fine_sel;

    // State update and result fields on commit
    always_comb begin
        n_last_count = r_last_count;
        n_accum      = r_accum;
        n_revs       = r_revs;
        n_index_seen = r_index_seen;
        n_speed_ref  = r_speed_ref;
        n_last_step  = r_last_step;
        w_out_raw    = '0;
        w_out_mech   = '0;
        w_out_elec   = '0;
        w_out_speed  = '0;
        case (r_op)
            OP_POS: begin
                w_out_raw    = r_raw;
                w_out_mech   = r_mech;
                w_out_elec   = (r_elec_prod << 1) + r_cal_angle;
                n_last_step  = r_step_new;
                n_last_count = r_cnt;
                n_accum      = r_accum + r_step_new;
                if (r_idx) begin
                    n_index_seen = 1'b1;
                    n_revs       = r_fwd ? (r_revs + TURNS_W'(1)) : (r_revs - TURNS_W'(1));
                end
            end
            OP_VEL: begin
                w_out_speed = w_speed;
                n_speed_ref = r_accum;
            end
            OP_ZERO: begin
                n_accum      = '0;
                n_revs       = '0;
                n_last_count = r_cnt;
                n_speed_ref  = '0;
                n_last_step  = '0;
            end
            default: begin
                // unused code: report the state unchanged
                n_accum = r_accum;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_count <= '0;
            r_accum      <= '0;
            r_revs       <= '0;
            r_index_seen <= 1'b0;
            r_speed_ref  <= '0;
            r_last_step  <= '0;
        end else if (i_cmd.commit) begin
            r_last_count <= n_last_count;
            r_accum      <= n_accum;
            r_revs       <= n_revs;
            r_index_seen <= n_index_seen;
            r_speed_ref  <= n_speed_ref;
            r_last_step  <= n_last_step;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_position   <= n_accum;
            o_step       <= n_last_step;
            o_turns      <= n_revs;
            o_raw_angle  <= w_out_raw;
            o_mech_angle <= w_out_mech;
            o_elec_angle <= w_out_elec;
            o_use_hall   <= !r_sine_mode || !n_index_seen;
            o_speed      <= w_out_speed;
        end
    end

endmodule

>>> rtl/core/quadrature_position_speed_tracker.sv
// ----------------------------------------------------------------------------
// Quadrature position and speed tracker
// Unwraps quadrature counter snapshots into a signed position, revolution
// count and angles, and forms a coarse plus fine speed on velocity words.
//
//   channel   direction  handshake                 contents
//   s_axis    in         tvalid/tready             tuser: operation
//                                                  tdata: counter snapshot
//   m_axis    out        tvalid/tready             tdata: position result
//   cfg       in         write enable, no wait     index 0..3, 32-bit data
//
// Sequence: with the output register free, a position, zero or unused-code word
// passes through its front and commit steps between accepts; a velocity word adds
// the 40-step restoring divider that forms the fine speed term one quotient bit a
// cycle, and then the scaling multiply.
// Reset is synchronous: tracking state clears, configuration takes defaults.
// A finished word waits in the output register; the next input word is taken
// meanwhile and its commit holds until the output register is free.
// ----------------------------------------------------------------------------
`include "quadrature_position_speed_tracker_defines.svh"

module quadrature_position_speed_tracker #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input words
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // count[31:0], index_count[63:32], dir_forward[64], index_event[65],
    // cap_timer[81:66], cap_period[97:82], cap_overflow[98], dir_changed[99]
    input  logic [103:0]  i_s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]    i_s_axis_tuser,
    // result words
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // position[31:0], step[63:32], turns[79:64], raw_angle[111:80],
    // mech_angle[143:112], elec_angle[175:144], use_hall[176], speed[208:177]
    output logic [215:0]  o_m_axis_tdata,
    // configuration
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import qpst_pkg::*;

    t_ctl_cmd                   w_cmd;
    t_ctl_sts                   w_sts;
    logic signed [WORD_W-1:0]   w_position, w_step, w_speed;
    logic signed [TURNS_W-1:0]  w_turns;
    logic [WORD_W-1:0]          w_raw, w_mech, w_elec;
    logic                       w_use_hall;

    // Sequence control
    qpst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid)
    );

    // Arithmetic and state
    qpst_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_s_axis_tuser),
        .i_count        (i_s_axis_tdata[31:0]),
        .i_index_count  (i_s_axis_tdata[63:32]),
        .i_dir_forward  (i_s_axis_tdata[64]),
        .i_index_event  (i_s_axis_tdata[65]),
        .i_cap_timer    (i_s_axis_tdata[81:66]),
        .i_cap_period   (i_s_axis_tdata[97:82]),
        .i_cap_overflow (i_s_axis_tdata[98]),
        .i_dir_changed  (i_s_axis_tdata[99]),
        .o_position     (w_position),
        .o_step         (w_step),
        .o_turns        (w_turns),
        .o_raw_angle    (w_raw),
        .o_mech_angle   (w_mech),
        .o_elec_angle   (w_elec),
        .o_use_hall     (w_use_hall),
        .o_speed        (w_speed)
    );

    // Pack the result word
    assign o_m_axis_tdata = {7'b0, w_speed, w_use_hall, w_elec, w_mech, w_raw,
                             w_turns, w_step, w_position};

    // One word in flight: ready drops right after an accept
    `QPST_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input accepted while a word is in flight")

    // Never overwrite a result word that has not been taken
    `QPST_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_cmd.commit, !o_m_axis_tvalid || i_m_axis_tready, "result word overwritten")

    // The last divide step is followed by the scaling multiply
    `QPST_ASSERT_NEXT(a_div_then_mul, i_clk, i_rst_n, w_cmd.div_step && w_sts.div_done, w_cmd.mul, "divide did not hand over to multiply")

endmodule
